// ===== hdl/assert_macros.svh =====
// assertion helpers used by pbp_ctrl
// both expect a clock named clk and an active-low reset named rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_AT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: property check failed");

// expression must never be true at a clock edge outside reset
`define ASSERT_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("%m: forbidden condition seen");

`endif

// ===== hdl/pbp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbp_pkg
// shared types, codes and fixed widths of the page buffer pool replacement unit
// ----------------------------------------------------------------------------
package pbp_pkg;

    // fixed field widths
    localparam int PAGE_W      = 24;
    localparam int FRAME_OUT_W = 4;
    localparam int COUNT_W     = 32;
    localparam int PIN_W       = 8;
    localparam int OP_W        = 3;
    localparam int STATUS_W    = 2;
    localparam int OUT_DATA_W  = 120;

    // flush-all emits at most this many write-backs
    localparam int MAX_RESULTS  = 16;
    localparam int FLUSH_CNT_W  = $clog2(MAX_RESULTS + 1);

    // pin count saturation value
    localparam logic [PIN_W-1:0] PIN_MAX = 8'hFF;

    // request opcodes
    localparam logic [OP_W-1:0] OP_PIN   = 3'd0;
    localparam logic [OP_W-1:0] OP_UNPIN = 3'd1;
    localparam logic [OP_W-1:0] OP_DIRTY = 3'd2;
    localparam logic [OP_W-1:0] OP_FORCE = 3'd3;
    localparam logic [OP_W-1:0] OP_FLUSH = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    // replacement policy codes
    localparam logic RS_FIFO = 1'b0;
    localparam logic RS_LRU  = 1'b1;

    // one result item
    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [FRAME_OUT_W-1:0] frame_index;
        logic                   writeback_valid;
        logic [PAGE_W-1:0]      writeback_page;
        logic                   load_valid;
        logic [PAGE_W-1:0]      load_page;
        logic [COUNT_W-1:0]     reads_total;
        logic [COUNT_W-1:0]     writes_total;
        logic                   last_result;
    } result_t;

endpackage

// ===== hdl/page_buffer_pool_replacement_unit.sv =====
// pin, unpin, mark dirty and force start with a lookup pass, then pin runs an update
// pass unless no frame can take the page and the others rewrite the hit frame. flush
// all reads the frames in turn, waiting while the output stalls. one request at a time,
// next accepted after its last result leaves the sequencer. both passes visit one frame
// per cycle on the single frame-table read port. reset empties every frame, clears the
// counters and the fifo pointer and selects fifo replacement: no table clearing pass
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_buffer_pool_replacement_unit
// fully associative page frame table with fifo or lru victim choice
// ----------------------------------------------------------------------------
module page_buffer_pool_replacement_unit #(
    parameter int NUM_FRAMES = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic                              cfg_wdata,      // replace_policy
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [pbp_pkg::PAGE_W-1:0]        s_axis_tdata,   // page_number
    input  logic [pbp_pkg::OP_W-1:0]          s_axis_tuser,   // opcode
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // status, frame_index, writeback_valid, writeback_page, load_valid,
    // load_page, reads_total, writes_total
    output logic [pbp_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic                              m_axis_tlast    // last_result
);

    import pbp_pkg::*;

    logic    policy_reg;
    logic    out_vld_reg;
    result_t out_reg;
    logic    out_free;
    logic    res_valid;
    result_t res;

    // replacement policy register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= RS_FIFO;
        end
        else if (cfg_we)
        begin
            policy_reg <= cfg_wdata;
        end
    end

    pbp_ctrl #(
        .NUM_FRAMES (NUM_FRAMES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .policy    (policy_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_op     (s_axis_tuser),
        .in_page   (s_axis_tdata),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res)
    );

    // output register, free when empty or being taken
    assign out_free = !out_vld_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
            out_reg     <= '0;
        end
        else if (res_valid)
        begin
            out_vld_reg <= 1'b1;
            out_reg     <= res;
        end
        else if (m_axis_tready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    // result transaction packing
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tlast  = out_reg.last_result;
    assign m_axis_tdata  = {out_reg.writes_total, out_reg.reads_total, out_reg.load_page,
                            out_reg.load_valid, out_reg.writeback_page,
                            out_reg.writeback_valid, out_reg.frame_index, out_reg.status};

endmodule

// ===== hdl/pbp_frame_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbp_frame_ram
// frame table memory: one write port, one read port with registered data
// ----------------------------------------------------------------------------
module pbp_frame_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 37
) (
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data registered
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/pbp_ctrl.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// pbp_ctrl
// request sequencer: walks the frame table through a shared compare/update
// step: one frame per cycle in the lookup and recency update passes, a read then a check per frame in flush
// ----------------------------------------------------------------------------
module pbp_ctrl #(
    parameter int NUM_FRAMES = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          policy,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [pbp_pkg::OP_W-1:0]      in_op,
    input  logic [pbp_pkg::PAGE_W-1:0]    in_page,
    input  logic                          out_free,
    output logic                          res_valid,
    output pbp_pkg::result_t              res
);

    import pbp_pkg::*;

    localparam int FW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int CW = $clog2(NUM_FRAMES + 1);
    localparam int RW = CW;
    localparam int DW = PAGE_W + PIN_W + 1 + RW;
    localparam logic [FW-1:0] LAST_IDX    = FW'(NUM_FRAMES - 1);
    localparam logic [CW-1:0] ISS_END     = CW'(NUM_FRAMES);
    localparam logic [RW-1:0] RANK_OLDEST = RW'(NUM_FRAMES);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_TOUCH,
        S_MOD_RD,
        S_MOD_WR,
        S_FL_RD,
        S_FL_CHK,
        S_EMIT
    } state_t;

    // sequencer state
    state_t                   state_reg, state_next;
    logic [OP_W-1:0]          op_reg, op_next;
    logic [PAGE_W-1:0]        page_reg, page_next;
    logic [CW-1:0]            iss_reg, iss_next;
    logic                     pv_reg, pv_next;
    logic [FW-1:0]            pidx_reg, pidx_next;

    // lookup pass results
    logic                     hit_fnd_reg, hit_fnd_next;
    logic [FW-1:0]            hit_f_reg, hit_f_next;
    logic [RW-1:0]            hit_rank_reg, hit_rank_next;
    logic                     emp_fnd_reg, emp_fnd_next;
    logic [FW-1:0]            emp_f_reg, emp_f_next;
    logic                     fa_fnd_reg, fa_fnd_next;
    logic [FW-1:0]            fa_f_reg, fa_f_next;
    logic [RW-1:0]            fa_rank_reg, fa_rank_next;
    logic                     fb_fnd_reg, fb_fnd_next;
    logic [FW-1:0]            fb_f_reg, fb_f_next;
    logic [RW-1:0]            fb_rank_reg, fb_rank_next;
    logic                     lru_fnd_reg, lru_fnd_next;
    logic [FW-1:0]            lru_f_reg, lru_f_next;
    logic [RW-1:0]            lru_rank_reg, lru_rank_next;

    // update pass target
    logic [FW-1:0]            tgt_reg, tgt_next;
    logic [RW-1:0]            old_rank_reg, old_rank_next;
    logic                     was_occ_reg, was_occ_next;
    logic                     fill_reg, fill_next;
    logic                     wbv_reg, wbv_next;
    logic [PAGE_W-1:0]        wbp_reg, wbp_next;

    // architectural state
    logic [NUM_FRAMES-1:0]    occ_reg, occ_next;
    logic [FW-1:0]            fifo_next_reg, fifo_next_next;
    logic [COUNT_W-1:0]       reads_reg, reads_next;
    logic [COUNT_W-1:0]       writes_reg, writes_next;

    // result staging
    result_t                  res_reg, res_next;
    logic                     res_pend_reg, res_pend_next;
    logic [FLUSH_CNT_W-1:0]   nfl_reg, nfl_next;

    // frame memory port
    logic                     rd_en;
    logic [FW-1:0]            rd_addr;
    logic [DW-1:0]            rd_data;
    logic                     wr_en;
    logic [FW-1:0]            wr_addr;
    logic [DW-1:0]            wr_data;

    // fields of the entry read back
    logic [PAGE_W-1:0]        e_page;
    logic [PIN_W-1:0]         e_pins;
    logic                     e_dirty;
    logic [RW-1:0]            e_rank;

    function automatic result_t make_res(
        input logic [STATUS_W-1:0] st,
        input logic [FW-1:0]       f,
        input logic                wbv,
        input logic [PAGE_W-1:0]   wbp,
        input logic                ldv,
        input logic [PAGE_W-1:0]   ldp,
        input logic [COUNT_W-1:0]  rc,
        input logic [COUNT_W-1:0]  wc,
        input logic                last
    );
        result_t r;
        r.status          = st;
        r.frame_index     = FRAME_OUT_W'(f);
        r.writeback_valid = wbv;
        r.writeback_page  = wbp;
        r.load_valid      = ldv;
        r.load_page       = ldp;
        r.reads_total     = rc;
        r.writes_total    = wc;
        r.last_result     = last;
        return r;
    endfunction

    pbp_frame_ram #(
        .DEPTH (NUM_FRAMES),
        .AW    (FW),
        .DW    (DW)
    ) u_frame_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // entry layout: page, pins, dirty, recency rank
    assign e_page  = rd_data[DW-1 -: PAGE_W];
    assign e_pins  = rd_data[RW+1 +: PIN_W];
    assign e_dirty = rd_data[RW];
    assign e_rank  = rd_data[RW-1:0];

    assign res = res_reg;

    // sequencer and shared compare/update step
    always_comb
    begin
        logic                 take;
        logic [PAGE_W-1:0]    n_page;
        logic [PIN_W-1:0]     n_pins;
        logic                 n_dirty;
        logic [RW-1:0]        n_rank;
        logic                 wbv_now;
        logic [PAGE_W-1:0]    wbp_now;
        logic [COUNT_W-1:0]   rd_cnt;
        logic [COUNT_W-1:0]   wr_cnt;
        logic                 vic_fnd;
        logic [FW-1:0]        vic;
        logic [RW-1:0]        vic_rank;
        logic                 t_go;
        logic [FW-1:0]        t_f;
        logic [RW-1:0]        t_rank;
        logic                 t_was;

        state_next     = state_reg;
        op_next        = op_reg;
        page_next      = page_reg;
        iss_next       = iss_reg;
        pv_next        = pv_reg;
        pidx_next      = pidx_reg;
        hit_fnd_next   = hit_fnd_reg;
        hit_f_next     = hit_f_reg;
        hit_rank_next  = hit_rank_reg;
        emp_fnd_next   = emp_fnd_reg;
        emp_f_next     = emp_f_reg;
        fa_fnd_next    = fa_fnd_reg;
        fa_f_next      = fa_f_reg;
        fa_rank_next   = fa_rank_reg;
        fb_fnd_next    = fb_fnd_reg;
        fb_f_next      = fb_f_reg;
        fb_rank_next   = fb_rank_reg;
        lru_fnd_next   = lru_fnd_reg;
        lru_f_next     = lru_f_reg;
        lru_rank_next  = lru_rank_reg;
        tgt_next       = tgt_reg;
        old_rank_next  = old_rank_reg;
        was_occ_next   = was_occ_reg;
        fill_next      = fill_reg;
        wbv_next       = wbv_reg;
        wbp_next       = wbp_reg;
        occ_next       = occ_reg;
        fifo_next_next = fifo_next_reg;
        reads_next     = reads_reg;
        writes_next    = writes_reg;
        res_next       = res_reg;
        res_pend_next  = res_pend_reg;
        nfl_next       = nfl_reg;

        rd_en     = 1'b0;
        rd_addr   = iss_reg[FW-1:0];
        wr_en     = 1'b0;
        wr_addr   = pidx_reg;
        wr_data   = rd_data;
        res_valid = 1'b0;
        in_ready  = (state_reg == S_IDLE);

        take     = 1'b0;
        n_page   = e_page;
        n_pins   = e_pins;
        n_dirty  = e_dirty;
        n_rank   = e_rank;
        wbv_now  = wbv_reg;
        wbp_now  = wbp_reg;
        rd_cnt   = reads_reg;
        wr_cnt   = writes_reg;
        vic_fnd  = 1'b0;
        vic      = fb_f_reg;
        vic_rank = fb_rank_reg;
        t_go     = 1'b0;
        t_f      = hit_f_reg;
        t_rank   = hit_rank_reg;
        t_was    = 1'b1;

        // read issue shared by the two full-table passes
        if ((state_reg == S_SCAN) || (state_reg == S_TOUCH))
        begin
            if (iss_reg != ISS_END)
            begin
                rd_en     = 1'b1;
                rd_addr   = iss_reg[FW-1:0];
                iss_next  = CW'(iss_reg + 1'b1);
                pv_next   = 1'b1;
                pidx_next = iss_reg[FW-1:0];
            end
            else
            begin
                pv_next = 1'b0;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next   = in_op;
                    page_next = in_page;
                    case (in_op) inside
                        OP_PIN, OP_UNPIN, OP_DIRTY, OP_FORCE:
                        begin
                            iss_next     = '0;
                            pv_next      = 1'b0;
                            hit_fnd_next = 1'b0;
                            emp_fnd_next = 1'b0;
                            fa_fnd_next  = 1'b0;
                            fb_fnd_next  = 1'b0;
                            lru_fnd_next = 1'b0;
                            state_next   = S_SCAN;
                        end
                        OP_FLUSH:
                        begin
                            iss_next      = '0;
                            nfl_next      = '0;
                            res_pend_next = 1'b0;
                            state_next    = S_FL_RD;
                        end
                        default:
                        begin
                            res_next   = make_res(ST_OK, '0, 1'b0, '0, 1'b0, '0,
                                                  reads_reg, writes_reg, 1'b1);
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end

            // lookup pass: match, first empty, fifo and lru candidates
            S_SCAN:
            begin
                if (pv_reg)
                begin
                    if (occ_reg[pidx_reg] && (e_page == page_reg) && !hit_fnd_reg)
                    begin
                        hit_fnd_next  = 1'b1;
                        hit_f_next    = pidx_reg;
                        hit_rank_next = e_rank;
                    end
                    if (!occ_reg[pidx_reg] && !emp_fnd_reg)
                    begin
                        emp_fnd_next = 1'b1;
                        emp_f_next   = pidx_reg;
                    end
                    if (occ_reg[pidx_reg] && (e_pins == '0))
                    begin
                        if ((pidx_reg >= fifo_next_reg) && !fa_fnd_reg)
                        begin
                            fa_fnd_next  = 1'b1;
                            fa_f_next    = pidx_reg;
                            fa_rank_next = e_rank;
                        end
                        if (!fb_fnd_reg)
                        begin
                            fb_fnd_next  = 1'b1;
                            fb_f_next    = pidx_reg;
                            fb_rank_next = e_rank;
                        end
                        if (!lru_fnd_reg || (e_rank > lru_rank_reg))
                        begin
                            lru_fnd_next  = 1'b1;
                            lru_f_next    = pidx_reg;
                            lru_rank_next = e_rank;
                        end
                    end
                    if (pidx_reg == LAST_IDX)
                    begin
                        state_next = S_DECIDE;
                    end
                end
            end

            // choose the target frame from the pass results
            S_DECIDE:
            begin
                if (policy == RS_FIFO)
                begin
                    if (fa_fnd_reg)
                    begin
                        vic_fnd  = 1'b1;
                        vic      = fa_f_reg;
                        vic_rank = fa_rank_reg;
                    end
                    else if (fb_fnd_reg)
                    begin
                        vic_fnd  = 1'b1;
                        vic      = fb_f_reg;
                        vic_rank = fb_rank_reg;
                    end
                end
                else
                begin
                    vic_fnd  = lru_fnd_reg;
                    vic      = lru_f_reg;
                    vic_rank = lru_rank_reg;
                end

                case (op_reg) inside
                    OP_PIN:
                    begin
                        if (hit_fnd_reg)
                        begin
                            t_go      = 1'b1;
                            t_f       = hit_f_reg;
                            t_rank    = hit_rank_reg;
                            t_was     = 1'b1;
                            fill_next = 1'b0;
                        end
                        else if (emp_fnd_reg)
                        begin
                            t_go      = 1'b1;
                            t_f       = emp_f_reg;
                            t_rank    = RANK_OLDEST;
                            t_was     = 1'b0;
                            fill_next = 1'b1;
                        end
                        else if (vic_fnd)
                        begin
                            t_go      = 1'b1;
                            t_f       = vic;
                            t_rank    = vic_rank;
                            t_was     = 1'b1;
                            fill_next = 1'b1;
                            if (policy == RS_FIFO)
                            begin
                                fifo_next_next = (vic == LAST_IDX) ? '0 : FW'(vic + 1'b1);
                            end
                        end
                        else
                        begin
                            res_next   = make_res(ST_FULL, '0, 1'b0, '0, 1'b0, '0,
                                                  reads_reg, writes_reg, 1'b1);
                            state_next = S_EMIT;
                        end
                    end
                    OP_UNPIN, OP_DIRTY, OP_FORCE:
                    begin
                        if (hit_fnd_reg)
                        begin
                            tgt_next   = hit_f_reg;
                            state_next = S_MOD_RD;
                        end
                        else
                        begin
                            res_next   = make_res(ST_MISS, '0, 1'b0, '0, 1'b0, '0,
                                                  reads_reg, writes_reg, 1'b1);
                            state_next = S_EMIT;
                        end
                    end
                    default:
                    begin
                        res_next   = make_res(ST_OK, '0, 1'b0, '0, 1'b0, '0,
                                              reads_reg, writes_reg, 1'b1);
                        state_next = S_EMIT;
                    end
                endcase

                if (t_go)
                begin
                    tgt_next      = t_f;
                    old_rank_next = t_rank;
                    was_occ_next  = t_was;
                    wbv_next      = 1'b0;
                    iss_next      = '0;
                    pv_next       = 1'b0;
                    state_next    = S_TOUCH;
                end
            end

            // update pass: recency ranks, target entry, victim write-back
            S_TOUCH:
            begin
                if (pv_reg)
                begin
                    if (pidx_reg == tgt_reg)
                    begin
                        n_rank = '0;
                        if (fill_reg)
                        begin
                            n_page             = page_reg;
                            n_pins             = PIN_W'(1);
                            n_dirty            = 1'b0;
                            occ_next[pidx_reg] = 1'b1;
                            wbv_now            = was_occ_reg && e_dirty;
                            wbp_now            = e_page;
                        end
                        else if (e_pins != PIN_MAX)
                        begin
                            n_pins = PIN_W'(e_pins + 1'b1);
                        end
                    end
                    else if (occ_reg[pidx_reg] && (e_rank < old_rank_reg))
                    begin
                        n_rank = RW'(e_rank + 1'b1);
                    end

                    wr_en    = 1'b1;
                    wr_addr  = pidx_reg;
                    wr_data  = {n_page, n_pins, n_dirty, n_rank};
                    wbv_next = wbv_now;
                    wbp_next = wbp_now;

                    if (pidx_reg == LAST_IDX)
                    begin
                        if (fill_reg)
                        begin
                            rd_cnt      = COUNT_W'(reads_reg + 1'b1);
                            wr_cnt      = COUNT_W'(writes_reg + wbv_now);
                            reads_next  = rd_cnt;
                            writes_next = wr_cnt;
                            res_next    = make_res(ST_OK, tgt_reg, wbv_now,
                                                   wbv_now ? wbp_now : '0, 1'b1, page_reg,
                                                   rd_cnt, wr_cnt, 1'b1);
                        end
                        else
                        begin
                            res_next = make_res(ST_OK, tgt_reg, 1'b0, '0, 1'b0, '0,
                                                reads_reg, writes_reg, 1'b1);
                        end
                        state_next = S_EMIT;
                    end
                end
            end

            // single-frame read-modify-write for unpin, mark dirty, force
            S_MOD_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = tgt_reg;
                state_next = S_MOD_WR;
            end

            S_MOD_WR:
            begin
                wbv_now = 1'b0;
                case (op_reg)
                    OP_UNPIN:
                    begin
                        if (e_pins != '0)
                        begin
                            n_pins = PIN_W'(e_pins - 1'b1);
                        end
                    end
                    OP_DIRTY:
                    begin
                        n_dirty = 1'b1;
                    end
                    OP_FORCE:
                    begin
                        if (e_dirty)
                        begin
                            n_dirty = 1'b0;
                            wbv_now = 1'b1;
                            wr_cnt  = COUNT_W'(writes_reg + 1'b1);
                        end
                    end
                    default:
                    begin
                    end
                endcase
                wr_en       = 1'b1;
                wr_addr     = tgt_reg;
                wr_data     = {n_page, n_pins, n_dirty, n_rank};
                writes_next = wr_cnt;
                res_next    = make_res(ST_OK, tgt_reg, wbv_now, wbv_now ? e_page : '0,
                                       1'b0, '0, reads_reg, wr_cnt, 1'b1);
                state_next  = S_EMIT;
            end

            // flush: one frame read per visit
            S_FL_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = iss_reg[FW-1:0];
                pidx_next  = iss_reg[FW-1:0];
                state_next = S_FL_CHK;
            end

            // flush: clean a dirty frame, pass the held result on
            S_FL_CHK:
            begin
                take = occ_reg[pidx_reg] && e_dirty &&
                       (nfl_reg < FLUSH_CNT_W'(MAX_RESULTS));
                if (!(take && res_pend_reg && !out_free))
                begin
                    if (take)
                    begin
                        wr_en         = 1'b1;
                        wr_addr       = pidx_reg;
                        wr_data       = {e_page, e_pins, 1'b0, e_rank};
                        wr_cnt        = COUNT_W'(writes_reg + 1'b1);
                        writes_next   = wr_cnt;
                        nfl_next      = FLUSH_CNT_W'(nfl_reg + 1'b1);
                        res_valid     = res_pend_reg;
                        res_next      = make_res(ST_OK, pidx_reg, 1'b1, e_page, 1'b0, '0,
                                                 reads_reg, wr_cnt, pidx_reg == LAST_IDX);
                        res_pend_next = 1'b1;
                    end
                    if (pidx_reg == LAST_IDX)
                    begin
                        if (!take)
                        begin
                            if (res_pend_reg)
                            begin
                                res_next.last_result = 1'b1;
                            end
                            else
                            begin
                                res_next = make_res(ST_OK, '0, 1'b0, '0, 1'b0, '0,
                                                    reads_reg, writes_reg, 1'b1);
                            end
                        end
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        iss_next   = CW'(iss_reg + 1'b1);
                        state_next = S_FL_RD;
                    end
                end
            end

            // hand the final result to the output register
            S_EMIT:
            begin
                if (out_free)
                begin
                    res_valid     = 1'b1;
                    res_pend_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and staging registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= '0;
            page_reg      <= '0;
            iss_reg       <= '0;
            pv_reg        <= 1'b0;
            pidx_reg      <= '0;
            hit_fnd_reg   <= 1'b0;
            hit_f_reg     <= '0;
            hit_rank_reg  <= '0;
            emp_fnd_reg   <= 1'b0;
            emp_f_reg     <= '0;
            fa_fnd_reg    <= 1'b0;
            fa_f_reg      <= '0;
            fa_rank_reg   <= '0;
            fb_fnd_reg    <= 1'b0;
            fb_f_reg      <= '0;
            fb_rank_reg   <= '0;
            lru_fnd_reg   <= 1'b0;
            lru_f_reg     <= '0;
            lru_rank_reg  <= '0;
            tgt_reg       <= '0;
            old_rank_reg  <= '0;
            was_occ_reg   <= 1'b0;
            fill_reg      <= 1'b0;
            wbv_reg       <= 1'b0;
            wbp_reg       <= '0;
            occ_reg       <= '0;
            fifo_next_reg <= '0;
            reads_reg     <= '0;
            writes_reg    <= '0;
            res_reg       <= '0;
            res_pend_reg  <= 1'b0;
            nfl_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            page_reg      <= page_next;
            iss_reg       <= iss_next;
            pv_reg        <= pv_next;
            pidx_reg      <= pidx_next;
            hit_fnd_reg   <= hit_fnd_next;
            hit_f_reg     <= hit_f_next;
            hit_rank_reg  <= hit_rank_next;
            emp_fnd_reg   <= emp_fnd_next;
            emp_f_reg     <= emp_f_next;
            fa_fnd_reg    <= fa_fnd_next;
            fa_f_reg      <= fa_f_next;
            fa_rank_reg   <= fa_rank_next;
            fb_fnd_reg    <= fb_fnd_next;
            fb_f_reg      <= fb_f_next;
            fb_rank_reg   <= fb_rank_next;
            lru_fnd_reg   <= lru_fnd_next;
            lru_f_reg     <= lru_f_next;
            lru_rank_reg  <= lru_rank_next;
            tgt_reg       <= tgt_next;
            old_rank_reg  <= old_rank_next;
            was_occ_reg   <= was_occ_next;
            fill_reg      <= fill_next;
            wbv_reg       <= wbv_next;
            wbp_reg       <= wbp_next;
            occ_reg       <= occ_next;
            fifo_next_reg <= fifo_next_next;
            reads_reg     <= reads_next;
            writes_reg    <= writes_next;
            res_reg       <= res_next;
            res_pend_reg  <= res_pend_next;
            nfl_reg       <= nfl_next;
        end
    end

    // a result is only handed over when the output register can take it
    `ASSERT_AT(a_res_into_free_slot, res_valid |-> out_free)
    // frames are never released, so the occupied count only grows
    `ASSERT_AT(a_occ_grows, 1'b1 |=> ($countones(occ_reg) >= $past($countones(occ_reg))))
    // every pass read comes back for processing in the next cycle
    `ASSERT_AT(a_pass_read_returns, (rd_en && (state_reg == S_SCAN || state_reg == S_TOUCH)) |=> pv_reg)
    // no table write during idle, lookup or decision
    `ASSERT_NEVER(a_no_stray_write, wr_en && (state_reg == S_IDLE || state_reg == S_SCAN || state_reg == S_DECIDE))

endmodule
